@@ rtl/beacon_frame_bssid_tracker_assert.svh @@
// Assertion macros for the beacon tracker, clocked on clk and held off during rst.
`ifndef BEACON_FRAME_BSSID_TRACKER_ASSERT_SVH
`define BEACON_FRAME_BSSID_TRACKER_ASSERT_SVH

// same-cycle implication
`define BFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("beacon tracker check failed");

// next-cycle implication
`define BFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("beacon tracker check failed");

`endif

@@ rtl/bft_pkg.sv @@
// Shared types and constants for the beacon BSSID tracker.
package bft_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FILL_W        = $clog2(TABLE_ENTRIES + 1);
  localparam int SSID_MAX      = 32;
  localparam int SSID_SEL_W    = $clog2(SSID_MAX);

  typedef enum logic [2:0] {
    ST_SHORT      = 3'd0,
    ST_NOT_BEACON = 3'd1,
    ST_UPDATED    = 3'd2,
    ST_INSERTED   = 3'd3,
    ST_FULL       = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    R_PLAIN,
    R_FULL,
    R_UPDATE,
    R_INSERT,
    R_BYTE
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FINISH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_UPDATE,
    S_INSERT,
    S_FULL_RPT,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [47:0] bssid;
    logic [31:0] beacon_count;
    logic [5:0]  entry_index;
    logic [5:0]  ssid_length;
    logic [7:0]  ssid_byte;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    status_t     status;
    logic        table_op;
    logic [47:0] bssid;
    logic [5:0]  ssid_length;
  } pkt_info_t;

  typedef struct packed {
    logic clear;
    logic scan_start;
    logic scan_rd;
    logic scan_next;
    logic wr_update;
    logic wr_insert;
    logic load;
    res_t res;
    logic stream_start;
    logic stream_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic full;
    logic hit;
    logic stream_last;
  } tbl_stat_t;

endpackage

@@ rtl/bft_parser.sv @@
// Per-packet byte parser: radiotap length, frame control, BSSID and SSID tag walk.
module bft_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  bft_pkg::in_item_t             in_data,
  input  logic                          clear,
  input  logic [bft_pkg::SSID_SEL_W-1:0] ssid_sel,
  output bft_pkg::pkt_info_t            info,
  output logic [7:0]                    ssid_byte
);
  import bft_pkg::*;

  logic [15:0] pos;
  logic [15:0] rtlen;
  logic [7:0]  fc;
  logic [7:0]  head0;
  logic [7:0]  head1;
  logic [47:0] bssid_cap;
  logic [16:0] nto;
  logic [7:0]  tag_num;
  logic [7:0]  tag_len;
  logic        hdr_pend;
  logic        in_val;
  logic [7:0]  val_idx;
  logic        too_long;
  logic [7:0]  tag_buf [SSID_MAX];
  logic [7:0]  cap [SSID_MAX];
  logic [5:0]  cap_len;

  logic [7:0]  b;
  logic [16:0] p17;
  logic [15:0] rt_full;
  logic        too_long_now;
  logic        tag_done;
  logic [16:0] total;
  logic        beacon;

  assign b            = in_data.packet_byte;
  assign p17          = {1'b0, pos};
  assign rt_full      = {b, rtlen[7:0]};
  assign too_long_now = too_long || (pos == 16'hFFFF);
  assign tag_done     = in_val && ((p17 + 17'd1) == nto);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pos       <= '0;
      rtlen     <= '0;
      fc        <= '0;
      head0     <= '0;
      head1     <= '0;
      bssid_cap <= '0;
      nto       <= 17'h1FFFF;
      tag_num   <= '0;
      tag_len   <= '0;
      hdr_pend  <= 1'b0;
      in_val    <= 1'b0;
      val_idx   <= '0;
      too_long  <= 1'b0;
      cap_len   <= '0;
    end else if (take) begin
      too_long <= too_long_now;
      if (!in_data.end_of_packet && pos != 16'hFFFF) pos <= pos + 16'd1;
      if (!too_long_now) begin
        if (pos == 16'd0) head0 <= b;
        if (pos == 16'd1) head1 <= b;
        if (pos == 16'd2) rtlen <= {8'h00, b};
        if (pos == 16'd3) begin
          rtlen <= rt_full;
          nto   <= {1'b0, rt_full} + 17'd36;
          if (rt_full == 16'd0)      fc <= head0;
          else if (rt_full == 16'd1) fc <= head1;
          else if (rt_full == 16'd2) fc <= 8'd2;
          else if (rt_full == 16'd3) fc <= b;
        end
        if (pos >= 16'd4) begin
          if (pos == rtlen) fc <= b;
          if (p17 >= {1'b0, rtlen} + 17'd16 && p17 < {1'b0, rtlen} + 17'd22)
            bssid_cap <= {bssid_cap[39:0], b};
          if (p17 == nto) begin
            tag_num  <= b;
            hdr_pend <= 1'b1;
            in_val   <= 1'b0;
          end else if (hdr_pend) begin
            tag_len  <= b;
            nto      <= p17 + 17'd1 + {9'd0, b};
            hdr_pend <= 1'b0;
            in_val   <= (b != 8'd0);
            val_idx  <= '0;
          end else if (in_val) begin
            val_idx <= val_idx + 8'd1;
            if (tag_done) begin
              in_val <= 1'b0;
              if (tag_num == 8'd0)
                cap_len <= (tag_len < 8'(SSID_MAX)) ? tag_len[5:0] : 6'(SSID_MAX);
            end
          end
        end
      end
    end
  end

  // value bytes and the SSID copy; the copy takes the byte landing this cycle
  always_ff @(posedge clk) begin
    if (take && !too_long_now && pos >= 16'd4 && p17 != nto && !hdr_pend && in_val) begin
      for (int j = 0; j < SSID_MAX; j++) begin
        if (val_idx == 8'(j)) tag_buf[j] <= b;
        if (tag_done && tag_num == 8'd0)
          cap[j] <= (val_idx == 8'(j)) ? b : tag_buf[j];
      end
    end
  end

  assign total  = p17 + 17'd1;
  assign beacon = (fc[3:2] == 2'd0) && (fc[7:4] == 4'd8);

  always_comb begin
    info.table_op    = 1'b0;
    info.bssid       = bssid_cap;
    info.ssid_length = cap_len;
    if (too_long)
      info.status = ST_TOO_LONG;
    else if (total < 17'd8 || total < {1'b0, rtlen} + 17'd4)
      info.status = ST_SHORT;
    else if (!beacon)
      info.status = ST_NOT_BEACON;
    else if (total < {1'b0, rtlen} + 17'd36)
      info.status = ST_SHORT;
    else begin
      info.status   = ST_UPDATED;
      info.table_op = 1'b1;
    end
  end

  assign ssid_byte = cap[ssid_sel];

endmodule

@@ rtl/bft_table.sv @@
// BSSID table memory, scan counter, stream counter and output register.
module bft_table (
  input  logic                           clk,
  input  logic                           rst,
  input  bft_pkg::ctrl_cmd_t             cmd,
  input  bft_pkg::pkt_info_t             info,
  input  logic [7:0]                     ssid_byte,
  input  logic                           out_stall,
  output logic [bft_pkg::SSID_SEL_W-1:0] ssid_sel,
  output bft_pkg::tbl_stat_t             stat,
  output logic                           out_valid,
  output bft_pkg::out_item_t             out_data
);
  import bft_pkg::*;

  typedef struct packed {
    logic [47:0] bssid;
    logic [31:0] count;
    logic [5:0]  len;
  } entry_t;

  entry_t              mem [TABLE_ENTRIES];
  entry_t              rd_q;
  logic [FILL_W-1:0]   fill;
  logic [FILL_W-1:0]   scan_idx;
  logic [IDX_W-1:0]    ins_slot;
  logic [SSID_SEL_W-1:0] k;
  logic [31:0]         count_inc;
  out_item_t           res;

  assign count_inc = (rd_q.count == 32'hFFFF_FFFF) ? rd_q.count : rd_q.count + 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) rd_q <= mem[scan_idx[IDX_W-1:0]];
    if (cmd.wr_update)
      mem[scan_idx[IDX_W-1:0]] <= '{bssid: rd_q.bssid, count: count_inc, len: rd_q.len};
    else if (cmd.wr_insert)
      mem[fill[IDX_W-1:0]] <= '{bssid: info.bssid, count: 32'd1, len: info.ssid_length};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      scan_idx <= '0;
      k        <= '0;
    end else begin
      if (cmd.wr_insert) fill <= fill + FILL_W'(1);
      if (cmd.scan_start) scan_idx <= '0;
      else if (cmd.scan_next) scan_idx <= scan_idx + FILL_W'(1);
      if (cmd.stream_start) k <= '0;
      else if (cmd.stream_next) k <= k + SSID_SEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_insert) ins_slot <= fill[IDX_W-1:0];
  end

  assign ssid_sel         = k;
  assign stat.out_free    = !out_valid || !out_stall;
  assign stat.scan_end    = (scan_idx == fill);
  assign stat.full        = (fill == FILL_W'(TABLE_ENTRIES));
  assign stat.hit         = (rd_q.bssid == info.bssid);
  assign stat.stream_last = ({1'b0, k} + 6'd1) == info.ssid_length;

  always_comb begin
    res = '0;
    res.last_result = 1'b1;
    unique case (cmd.res)
      R_PLAIN: res.status = info.status;
      R_FULL: begin
        res.status = ST_FULL;
        res.bssid  = info.bssid;
      end
      R_UPDATE: begin
        res.status       = ST_UPDATED;
        res.bssid        = rd_q.bssid;
        res.beacon_count = count_inc;
        res.entry_index  = 6'(scan_idx[IDX_W-1:0]);
        res.ssid_length  = rd_q.len;
      end
      R_INSERT: begin
        res.status       = ST_INSERTED;
        res.bssid        = info.bssid;
        res.beacon_count = 32'd1;
        res.entry_index  = 6'(fill[IDX_W-1:0]);
        res.ssid_length  = info.ssid_length;
        res.last_result  = (info.ssid_length == 6'd0);
      end
      R_BYTE: begin
        res.kind         = 1'b1;
        res.status       = ST_INSERTED;
        res.bssid        = info.bssid;
        res.beacon_count = 32'd1;
        res.entry_index  = 6'(ins_slot);
        res.ssid_length  = info.ssid_length;
        res.ssid_byte    = ssid_byte;
        res.last_result  = stat.stream_last;
      end
      default: res.status = info.status;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_data <= res;
  end

endmodule

@@ rtl/bft_ctrl.sv @@
// Controller: end-of-packet decision, table scan, update/insert and SSID streaming.
module bft_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               end_of_packet,
  input  bft_pkg::pkt_info_t info,
  input  bft_pkg::tbl_stat_t stat,
  output logic               in_stall,
  output logic               take,
  output bft_pkg::ctrl_cmd_t cmd
);
  import bft_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = R_PLAIN;
    unique case (state)
      S_IDLE: if (take && end_of_packet) state_next = S_FINISH;
      S_FINISH: begin
        if (info.table_op) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN_RD;
        end else if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) state_next = stat.full ? S_FULL_RPT : S_INSERT;
        else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.hit) state_next = S_UPDATE;
        else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_UPDATE: begin
        cmd.res = R_UPDATE;
        if (stat.out_free) begin
          cmd.wr_update = 1'b1;
          cmd.load      = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_INSERT: begin
        cmd.res = R_INSERT;
        if (stat.out_free) begin
          cmd.wr_insert    = 1'b1;
          cmd.load         = 1'b1;
          cmd.stream_start = 1'b1;
          if (info.ssid_length == 6'd0) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else state_next = S_STREAM;
        end
      end
      S_FULL_RPT: begin
        cmd.res = R_FULL;
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        cmd.res = R_BYTE;
        if (stat.out_free) begin
          cmd.load        = 1'b1;
          cmd.stream_next = 1'b1;
          if (stat.stream_last) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/beacon_frame_bssid_tracker.sv @@
// Top level of the beacon BSSID tracker.
// Input channel: in_valid/in_stall carry one captured byte per item, with
// end_of_packet on the final byte. Bytes are taken one per cycle while the
// packet streams in; parsing runs in step with the bytes.
// After the final byte the input stalls while the packet is settled:
// the packet is first classified, then for a beacon the table is scanned entry
// by entry (registered read of the single table memory port, then compare) until
// a hit or the fill count, then the entry is updated, inserted or reported full.
// An insert is followed by one SSID byte item per cycle while out_stall allows
// it. Each result waits until out_stall lets it go.
// Output channel: out_valid/out_stall; one registered result item. When the
// receiver stalls, the item holds and the controller waits in place.
// Reset (rst, synchronous) empties the table through its fill count and clears
// all per-packet state; no clearing pass is needed.
// Packets above 65535 bytes are reported as too long without table action.
module beacon_frame_bssid_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bft_pkg::out_item_t out_data
);
  import bft_pkg::*;

  `include "beacon_frame_bssid_tracker_assert.svh"

  logic                  take;
  ctrl_cmd_t             cmd;
  tbl_stat_t             stat;
  pkt_info_t             info;
  logic [7:0]            ssid_byte;
  logic [SSID_SEL_W-1:0] ssid_sel;

  bft_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .end_of_packet (in_data.end_of_packet),
    .info          (info),
    .stat          (stat),
    .in_stall      (in_stall),
    .take          (take),
    .cmd           (cmd)
  );

  bft_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_data   (in_data),
    .clear     (cmd.clear),
    .ssid_sel  (ssid_sel),
    .info      (info),
    .ssid_byte (ssid_byte)
  );

  bft_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .info      (info),
    .ssid_byte (ssid_byte),
    .out_stall (out_stall),
    .ssid_sel  (ssid_sel),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `BFT_ASSERT_NEXT(a_eop_stalls, take && in_data.end_of_packet, in_stall)
  `BFT_ASSERT_NOW(a_byte_is_insert, out_valid && out_data.kind,
                  out_data.status == ST_INSERTED)
  `BFT_ASSERT_NOW(a_plain_is_last,
                  out_valid && !out_data.kind && (out_data.status == ST_SHORT ||
                  out_data.status == ST_NOT_BEACON || out_data.status == ST_TOO_LONG),
                  out_data.last_result && out_data.bssid == 48'd0)
  `BFT_ASSERT_NOW(a_load_when_free, cmd.load, stat.out_free)

endmodule

@@ tb/tb_beacon_frame_bssid_tracker.sv @@
// Testbench for the beacon BSSID tracker: directed and random packets against a predictor.
module tb_beacon_frame_bssid_tracker;
  import bft_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int NOWHERE     = 'h1FFFF;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  beacon_frame_bssid_tracker uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // parser shadow
  int         pos, rtl, ntag;
  bit [7:0]   fcl, hb0, hb1;
  bit [47:0]  id_cap;
  bit [15:0]  tnl;
  bit         hdr_pend, in_val, too_long;
  bit [7:0]   tag_buf[SSID_MAX];
  bit [7:0]   ssid_cap[SSID_MAX];
  int         ssid_cap_len;
  // access point table shadow
  bit         ap_used[TABLE_ENTRIES];
  bit [47:0]  ap_id[TABLE_ENTRIES];
  bit [31:0]  ap_cnt[TABLE_ENTRIES];
  bit [5:0]   ap_len[TABLE_ENTRIES];
  bit [7:0]   ap_ssid[TABLE_ENTRIES][SSID_MAX];

  out_item_t  pending_results[$];
  status_t    report_status;
  int         errors = 0;
  int         cycles = 0;
  int         n_results = 0;
  int         n_status[8];
  int         n_bytes = 0;
  int         n_packets = 0;

  bit [7:0]   pkt[$];
  bit         calm = 1'b0;
  bit         no_gaps = 1'b0;
  int         hold_left = 0;
  bit [47:0]  id_pool[100];

  function automatic void clear_pkt();
    pos = 0; rtl = 0; fcl = 0; id_cap = 0; ntag = NOWHERE; tnl = 0;
    ssid_cap_len = 0; hb0 = 0; hb1 = 0;
    hdr_pend = 0; in_val = 0; too_long = 0;
  endfunction

  function automatic void walk_tag(int p, bit [7:0] b);
    int num, len, idx, n;
    num = tnl[15:8];
    len = tnl[7:0];
    if (p == ntag) begin
      tnl = {b, 8'h00}; hdr_pend = 1; in_val = 0;
    end else if (hdr_pend) begin
      tnl[7:0] = b; ntag = p + 1 + b; hdr_pend = 0; in_val = (b > 0);
    end else if (in_val) begin
      idx = p - (ntag - len);
      if (idx < SSID_MAX) tag_buf[idx] = b;
      if (p + 1 == ntag) begin
        in_val = 0;
        if (num == 0) begin
          n = (len < SSID_MAX) ? len : SSID_MAX;
          for (int i = 0; i < n; i++) ssid_cap[i] = tag_buf[i];
          ssid_cap_len = n;
        end
      end
    end
  endfunction

  function automatic void parse(int p, bit [7:0] b);
    if (p == 0) hb0 = b;
    if (p == 1) hb1 = b;
    if (p == 2) rtl = b;
    if (p == 3) begin
      rtl = rtl | (int'(b) << 8);
      ntag = rtl + 36;
      // short radiotap header: frame control lands inside the header itself
      if (rtl == 0) fcl = hb0;
      else if (rtl == 1) fcl = hb1;
      else if (rtl == 2) fcl = 8'd2;
      else if (rtl == 3) fcl = b;
    end
    if (p >= 4) begin
      if (p == rtl) fcl = b;
      if (p >= rtl + 16 && p < rtl + 22) id_cap = {id_cap[39:0], b};
      walk_tag(p, b);
    end
  endfunction

  function automatic void push_result(bit k, status_t st, bit [47:0] id, bit [31:0] cnt,
                                      int idx, int len, bit [7:0] sb, bit lst);
    out_item_t r;
    r.kind = k; r.status = st; r.bssid = id; r.beacon_count = cnt;
    r.entry_index = idx[5:0]; r.ssid_length = len[5:0]; r.ssid_byte = sb;
    r.last_result = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void settle_packet(int p);
    int total, slot, n;
    bit beacon;
    total = p + 1;
    beacon = (fcl[3:2] == 2'd0) && (fcl[7:4] == 4'd8);
    if (too_long) report_status = ST_TOO_LONG;
    else if (total < 8 || total < rtl + 4) report_status = ST_SHORT;
    else if (!beacon) report_status = ST_NOT_BEACON;
    else if (total < rtl + 36) report_status = ST_SHORT;
    else begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (ap_used[i] && ap_id[i] == id_cap) begin
          if (ap_cnt[i] != 32'hFFFF_FFFF) ap_cnt[i]++;
          report_status = ST_UPDATED;
          push_result(0, ST_UPDATED, id_cap, ap_cnt[i], i, ap_len[i], 0, 1);
          return;
        end
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!ap_used[i] && slot < 0) slot = i;
      if (slot < 0) begin
        report_status = ST_FULL;
        push_result(0, ST_FULL, id_cap, 0, 0, 0, 0, 1);
        return;
      end
      n = ssid_cap_len;
      ap_used[slot] = 1; ap_id[slot] = id_cap; ap_cnt[slot] = 1; ap_len[slot] = n[5:0];
      for (int i = 0; i < n; i++) ap_ssid[slot][i] = ssid_cap[i];
      report_status = ST_INSERTED;
      push_result(0, ST_INSERTED, id_cap, 1, slot, n, 0, n == 0);
      for (int i = 0; i < n; i++)
        push_result(1, ST_INSERTED, id_cap, 1, slot, n, ap_ssid[slot][i], i + 1 == n);
      return;
    end
    push_result(0, report_status, 0, 0, 0, 0, 0, 1);
  endfunction

  function automatic void track_byte(bit [7:0] b, bit lst);
    int p;
    p = pos;
    if (p == 'hFFFF) too_long = 1;
    if (!too_long) parse(p, b);
    if (!lst) begin
      if (pos < 'hFFFF) pos++;
    end else begin
      settle_packet(p);
      clear_pkt();
    end
  endfunction

  // packet construction
  function automatic void add_tag(bit [7:0] num, int len);
    pkt.push_back(num);
    pkt.push_back(len[7:0]);
    for (int i = 0; i < len; i++) pkt.push_back(8'($urandom_range(0, 255)));
  endfunction

  // ssid_n < 0: no SSID tag; cut > 0 forces total length; junk adds extra tags
  function automatic void build_beacon(int r, bit [7:0] fc, bit [47:0] id, int ssid_n,
                                       int junk, int cut);
    pkt.delete();
    for (int i = 0; i < r + 36; i++) pkt.push_back(8'($urandom_range(0, 255)));
    pkt[r] = fc;
    for (int i = 0; i < 6; i++) pkt[r + 16 + i] = id[47 - 8*i -: 8];
    if (pkt.size() < 4) while (pkt.size() < 4) pkt.push_back(8'd0);
    pkt[2] = r[7:0];
    pkt[3] = r[15:8];
    // with a short header, frame control re-written after the length bytes
    if (r < 2) pkt[r] = fc;
    for (int t = 0; t < junk; t++)
      if ($urandom_range(0, 3) == 0) add_tag(8'd0, $urandom_range(0, 40));
      else add_tag(8'($urandom_range(1, 255)), $urandom_range(0, 12));
    if (ssid_n >= 0) add_tag(8'd0, ssid_n);
    if (junk > 0 && $urandom_range(0, 1))
      add_tag(8'($urandom_range(0, 255)), $urandom_range(0, 8));
    if (cut > 0) begin
      while (pkt.size() > cut) void'(pkt.pop_back());
      while (pkt.size() < cut) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_packet();
    int gap;
    foreach (pkt[i]) begin
      gap = (calm || no_gaps) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data.packet_byte   <= pkt[i];
      in_data.end_of_packet <= (i == pkt.size() - 1);
      do @(posedge clk); while (in_stall);
      track_byte(pkt[i], i == pkt.size() - 1);
      n_bytes++;
    end
    n_packets++;
  endtask

  // receiver: random stall after every result, none when calm
  always @(posedge clk) begin
    int nxt;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      nxt = calm ? 0 : $urandom_range(0, 15);
      hold_left <= nxt;
      out_stall <= (nxt > 0);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want !== out_data) begin
          errors++;
          $display("%0t result mismatch: expected %h, got %h", $realtime, want, out_data);
          $display("  kind %0d/%0d status %0d/%0d bssid %h/%h count %0d/%0d", want.kind,
                   out_data.kind, want.status, out_data.status, want.bssid, out_data.bssid,
                   want.beacon_count, out_data.beacon_count);
          $display("  index %0d/%0d len %0d/%0d byte %h/%h last %0d/%0d", want.entry_index,
                   out_data.entry_index, want.ssid_length, out_data.ssid_length,
                   want.ssid_byte, out_data.ssid_byte, want.last_result, out_data.last_result);
        end
        if (want.kind == 1'b0) n_status[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout, %0d results still expected", $realtime, pending_results.size());
      $display("tb_beacon_frame_bssid_tracker: FAIL");
      $finish;
    end
  end

  typedef struct {
    int        r;
    bit [7:0]  fc;
    bit [47:0] id;
    int        ssid_n;
    int        junk;
    int        cut;
    int        want_status;   // -1: predictor only
  } recipe_t;

  recipe_t recipes[] = '{
    '{8,   8'h80, 48'h0011_2233_4455, 5,  0, 7,  ST_SHORT},
    '{8,   8'h80, 48'h0011_2233_4455, 5,  0, 1,  ST_SHORT},
    '{8,   8'h08, 48'h0011_2233_4455, 5,  0, 0,  ST_NOT_BEACON},
    '{8,   8'hFF, 48'h0011_2233_4455, 5,  0, 0,  ST_NOT_BEACON},
    '{8,   8'h80, 48'h0011_2233_4455, 5,  0, 0,  ST_INSERTED},
    '{8,   8'h80, 48'h0011_2233_4455, 9,  2, 0,  ST_UPDATED},
    '{8,   8'h80, 48'h0000_0000_0000, 32, 0, 0,  ST_INSERTED},
    '{8,   8'h80, 48'hFFFF_FFFF_FFFF, 40, 0, 0,  ST_INSERTED},
    '{12,  8'h80, 48'hA5A5_5A5A_0F0F, 0,  0, 0,  ST_INSERTED},
    '{12,  8'h80, 48'h5A5A_A5A5_F0F0, -1, 3, 0,  ST_INSERTED},
    '{0,   8'h80, 48'h1234_5678_9ABC, 3,  1, 0,  -1},
    '{1,   8'h80, 48'h2345_6789_ABCD, 3,  1, 0,  -1},
    '{2,   8'h80, 48'h3456_789A_BCDE, 3,  0, 0,  ST_NOT_BEACON},
    '{3,   8'h80, 48'h4567_89AB_CDEF, 3,  0, 0,  ST_NOT_BEACON},
    '{300, 8'h80, 48'h0102_0304_0506, 7,  2, 0,  ST_INSERTED},
    '{20,  8'h80, 48'h0607_0809_0A0B, 4,  0, 40, ST_SHORT},
    '{20,  8'h80, 48'h0607_0809_0A0B, 4,  0, 23, ST_SHORT},
    '{60,  8'h80, 48'h0607_0809_0A0B, 4,  0, 50, ST_SHORT},
    '{8,   8'h80, 48'hDEAD_BEEF_0001, 6,  0, 51, -1},
    '{8,   8'h80, 48'hDEAD_BEEF_0002, 6,  0, 48, -1},
    '{8,   8'h84, 48'hDEAD_BEEF_0003, 6,  0, 0,  ST_NOT_BEACON},
    '{8,   8'h83, 48'hDEAD_BEEF_0004, 6,  0, 0,  ST_INSERTED},
    '{8,   8'h80, 48'hDEAD_BEEF_0004, 6,  0, 0,  ST_UPDATED}
  };

  initial begin
    int pick, k;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    clear_pkt();
    foreach (ap_used[i]) ap_used[i] = 0;
    foreach (n_status[i]) n_status[i] = 0;
    foreach (id_pool[i]) id_pool[i] = 48'({$urandom(), $urandom()});
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (recipes[i]) begin
      build_beacon(recipes[i].r, recipes[i].fc, recipes[i].id, recipes[i].ssid_n,
                   recipes[i].junk, recipes[i].cut);
      send_packet();
      if (recipes[i].want_status >= 0 && int'(report_status) != recipes[i].want_status) begin
        errors++;
        $display("%0t packet %0d: expected status %0d, got %0d", $realtime, i,
                 recipes[i].want_status, report_status);
      end
    end

    // one packet past the 65535 byte limit, sent without gaps
    no_gaps = 1'b1;
    build_beacon(8, 8'h80, 48'hCAFE_0000_0001, 4, 0, 65540);
    send_packet();
    if (report_status != ST_TOO_LONG) begin
      errors++;
      $display("%0t long packet: expected status %0d, got %0d", $realtime, ST_TOO_LONG,
               report_status);
    end
    no_gaps = 1'b0;

    for (int n = 0; n < 170; n++) begin
      if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      if (pick < 70)
        build_beacon(($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40),
                     8'h80 | 8'($urandom_range(0, 3)), id_pool[k],
                     $urandom_range(0, 3) == 0 ? -1 : $urandom_range(0, 40),
                     $urandom_range(0, 4), 0);
      else if (pick < 82)
        build_beacon($urandom_range(4, 30), 8'($urandom_range(0, 255)), id_pool[k],
                     $urandom_range(0, 10), $urandom_range(0, 2), 0);
      else if (pick < 94)
        build_beacon($urandom_range(4, 30), 8'h80, id_pool[k], $urandom_range(0, 40),
                     $urandom_range(0, 3), $urandom_range(1, 90));
      else begin
        pkt.delete();
        for (int i = 0; i < $urandom_range(1, 20); i++)
          pkt.push_back(8'($urandom_range(0, 255)));
      end
      send_packet();
    end
    in_valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d packets, %0d bytes, %0d results checked", n_packets, n_bytes, n_results);
    $display("reports: short %0d, not beacon %0d, updated %0d, inserted %0d, full %0d, long %0d",
             n_status[ST_SHORT], n_status[ST_NOT_BEACON], n_status[ST_UPDATED],
             n_status[ST_INSERTED], n_status[ST_FULL], n_status[ST_TOO_LONG]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_beacon_frame_bssid_tracker: PASS");
    end else begin
      $display("tb_beacon_frame_bssid_tracker: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bft_pkg.sv
rtl/bft_parser.sv
rtl/bft_table.sv
rtl/bft_ctrl.sv
rtl/beacon_frame_bssid_tracker.sv
tb/tb_beacon_frame_bssid_tracker.sv
